/* rtl/vlrr_pkg.sv */
// vlrr_pkg: shared constants, codes and transaction types of the
// variable-length record ring. No dependencies.
package vlrr_pkg;

	localparam int RING_WORDS        = 1024;
	localparam int MAX_PAYLOAD_WORDS = 15;

	localparam int AW = $clog2(RING_WORDS);
	localparam int CW = $clog2(RING_WORDS + 1);
	localparam int PW = ((CW > 16) ? CW : 16) + 1;

	localparam int POP_MAX = (MAX_PAYLOAD_WORDS < 15) ? MAX_PAYLOAD_WORDS : 15;

	localparam logic [1:0] MODE_BEGIN = 2'd0;
	localparam logic [1:0] MODE_WORD  = 2'd1;
	localparam logic [1:0] MODE_POP   = 2'd2;

	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_SEQ    = 3'd2;
	localparam logic [2:0] ST_HEADER = 3'd3;
	localparam logic [2:0] ST_WORD   = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] tag;
		logic [3:0]  length;
		logic [31:0] data;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] tag_res;
		logic [31:0] data_res;
		logic        last;
		logic [10:0] used_words;
	} res_t;

	typedef struct packed {
		logic       latch;
		logic       emit_code;
		logic [2:0] code;
		logic       wr_marker;
		logic       wr_header;
		logic       wr_word;
		logic       rd_rp;
		logic       rd_zero;
		logic       pop_head;
		logic       pop_word;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       push_open;
		logic       fit;
		logic       wrap;
		logic       empty;
		logic       marker;
		logic       plen_zero;
		logic       cnt_last;
	} stat_t;

endpackage

/* rtl/vlrr_dp.sv */
// vlrr_dp: datapath of the record ring: ring memory, pointers, counters
// and the result register. Depends on vlrr_pkg.
module vlrr_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  vlrr_pkg::item_t item,
	input  vlrr_pkg::cmd_t  cmd,
	output vlrr_pkg::stat_t stat,
	output vlrr_pkg::res_t  res,
	output logic            res_stb
);

	localparam int AW = vlrr_pkg::AW;
	localparam int CW = vlrr_pkg::CW;
	localparam int PW = vlrr_pkg::PW;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(vlrr_pkg::RING_WORDS - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	vlrr_pkg::item_t item_q;
	logic [AW-1:0]   wp_q, rp_q, fill_q, cursor_q;
	logic [CW-1:0]   committed_q, reserve_q;
	logic [3:0]      left_q, cnt_q;
	logic            open_q, skip_q;
	logic [31:0]     mem [vlrr_pkg::RING_WORDS];
	logic [31:0]     rdata_q;
	vlrr_pkg::res_t  res_q;
	logic            stb_q;

	// push begin
	logic [CW-1:0] tail, alloc_nw, freew;
	logic [CW:0]   alloc;
	logic          wrap, too_long, fit;
	logic [AW-1:0] hdr_start;
	logic [31:0]   header;

	// pop
	logic [15:0]   total16, plen_full;
	logic [3:0]    plen;
	logic [CW-1:0] skip;
	logic [PW-1:0] pop, rp_sum;
	logic [AW-1:0] pop_start;

	// next state
	logic [AW-1:0]   wp_d, rp_d, fill_d, cursor_d;
	logic [CW-1:0]   committed_d, reserve_d;
	logic [3:0]      left_d, cnt_d;
	logic            open_d, skip_d, stb_d;
	vlrr_pkg::res_t  res_d;
	logic            we, re;
	logic [AW-1:0]   wa, ra;
	logic [31:0]     wd;
	logic            do_commit;
	logic [CW-1:0]   commit_amt;
	logic [CW:0]     c_sum, w_sum;

	assign tail      = CW'(vlrr_pkg::RING_WORDS) - CW'(wp_q);
	assign alloc_nw  = CW'(item_q.length) + 1'b1;
	assign wrap      = tail < alloc_nw;
	assign alloc     = wrap ? ((CW+1)'(alloc_nw) + (CW+1)'(tail)) : (CW+1)'(alloc_nw);
	assign freew     = CW'(vlrr_pkg::RING_WORDS) - committed_q;
	assign too_long  = 32'(item_q.length) > 32'(vlrr_pkg::MAX_PAYLOAD_WORDS);
	assign fit       = !too_long && ((CW+1)'(freew) >= alloc);
	assign hdr_start = wrap ? '0 : wp_q;
	assign header    = {item_q.tag, 16'(alloc_nw)};

	assign total16   = (rdata_q[15:0] == 16'd0) ? 16'd1 : rdata_q[15:0];
	assign plen_full = total16 - 16'd1;
	assign plen      = (plen_full > 16'(vlrr_pkg::POP_MAX)) ? 4'(vlrr_pkg::POP_MAX)
	                                                      : plen_full[3:0];
	assign skip      = skip_q ? (CW'(vlrr_pkg::RING_WORDS) - CW'(rp_q)) : '0;
	assign pop       = PW'(skip) + PW'(total16);
	assign rp_sum    = PW'(rp_q) + pop;
	assign pop_start = skip_q ? '0 : rp_q;

	assign stat.mode      = item_q.mode;
	assign stat.push_open = open_q;
	assign stat.fit       = fit;
	assign stat.wrap      = wrap;
	assign stat.empty     = committed_q == '0;
	assign stat.marker    = rdata_q[15:0] == 16'd0;
	assign stat.plen_zero = plen == 4'd0;
	assign stat.cnt_last  = cnt_q == 4'd1;

	always_comb begin
		wp_d        = wp_q;
		rp_d        = rp_q;
		fill_d      = fill_q;
		cursor_d    = cursor_q;
		committed_d = committed_q;
		reserve_d   = reserve_q;
		left_d      = left_q;
		cnt_d       = cnt_q;
		open_d      = open_q;
		skip_d      = skip_q;
		stb_d       = 1'b0;
		res_d       = '0;
		we          = 1'b0;
		wa          = wp_q;
		wd          = 32'd0;
		re          = 1'b0;
		ra          = rp_q;
		do_commit   = 1'b0;
		commit_amt  = reserve_q;

		if (cmd.emit_code) begin
			stb_d        = 1'b1;
			res_d.status = cmd.code;
			res_d.last   = 1'b1;
		end
		if (cmd.wr_marker) begin
			we = 1'b1;
			wa = wp_q;
			wd = 32'd0;
		end
		if (cmd.wr_header) begin
			we           = 1'b1;
			wa           = hdr_start;
			wd           = header;
			fill_d       = inc(hdr_start);
			stb_d        = 1'b1;
			res_d.status = vlrr_pkg::ST_ACCEPT;
			res_d.last   = 1'b1;
			if (item_q.length == 4'd0) begin
				do_commit  = 1'b1;
				commit_amt = CW'(alloc);
			end else begin
				reserve_d = CW'(alloc);
				left_d    = item_q.length;
				open_d    = 1'b1;
			end
		end
		if (cmd.wr_word) begin
			we           = 1'b1;
			wa           = fill_q;
			wd           = item_q.data;
			fill_d       = inc(fill_q);
			stb_d        = 1'b1;
			res_d.status = vlrr_pkg::ST_ACCEPT;
			res_d.last   = 1'b1;
			if (left_q > 4'd1) left_d = left_q - 4'd1;
			else do_commit = 1'b1;
		end
		if (do_commit) begin
			c_sum = (CW+1)'(committed_q) + (CW+1)'(commit_amt);
			if (c_sum > (CW+1)'(vlrr_pkg::RING_WORDS)) c_sum = (CW+1)'(vlrr_pkg::RING_WORDS);
			committed_d = CW'(c_sum);
			w_sum = (CW+1)'(wp_q) + (CW+1)'(commit_amt);
			if (w_sum >= (CW+1)'(vlrr_pkg::RING_WORDS))
				w_sum = w_sum - (CW+1)'(vlrr_pkg::RING_WORDS);
			wp_d      = AW'(w_sum);
			reserve_d = '0;
			left_d    = 4'd0;
			open_d    = 1'b0;
		end else begin
			c_sum = '0;
			w_sum = '0;
		end
		if (cmd.rd_rp) begin
			re     = 1'b1;
			ra     = rp_q;
			skip_d = 1'b0;
		end
		if (cmd.rd_zero) begin
			re     = 1'b1;
			ra     = '0;
			skip_d = 1'b1;
		end
		if (cmd.pop_head) begin
			if (rp_sum >= PW'(vlrr_pkg::RING_WORDS))
				rp_d = AW'(rp_sum - PW'(vlrr_pkg::RING_WORDS));
			else
				rp_d = AW'(rp_sum);
			committed_d    = (PW'(committed_q) > pop) ? CW'(PW'(committed_q) - pop) : '0;
			cnt_d          = plen;
			cursor_d       = inc(pop_start);
			re             = 1'b1;
			ra             = inc(pop_start);
			stb_d          = 1'b1;
			res_d.status   = vlrr_pkg::ST_HEADER;
			res_d.tag_res  = rdata_q[31:16];
			res_d.data_res = 32'(plen);
			res_d.last     = plen == 4'd0;
		end
		if (cmd.pop_word) begin
			cnt_d          = cnt_q - 4'd1;
			cursor_d       = inc(cursor_q);
			re             = 1'b1;
			ra             = inc(cursor_q);
			stb_d          = 1'b1;
			res_d.status   = vlrr_pkg::ST_WORD;
			res_d.data_res = rdata_q;
			res_d.last     = cnt_q == 4'd1;
		end
		res_d.used_words = 11'(committed_d);
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= item;
		cursor_q <= cursor_d;
		res_q    <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			fill_q      <= '0;
			committed_q <= '0;
			reserve_q   <= '0;
			left_q      <= '0;
			cnt_q       <= '0;
			open_q      <= 1'b0;
			skip_q      <= 1'b0;
			stb_q       <= 1'b0;
		end else begin
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			fill_q      <= fill_d;
			committed_q <= committed_d;
			reserve_q   <= reserve_d;
			left_q      <= left_d;
			cnt_q       <= cnt_d;
			open_q      <= open_d;
			skip_q      <= skip_d;
			stb_q       <= stb_d;
		end
	end

	assign res     = res_q;
	assign res_stb = stb_q;

endmodule

/* rtl/vlrr_ctrl.sv */
// vlrr_ctrl: sequencer of the record ring; issues datapath commands per
// transaction. Depends on vlrr_pkg.
module vlrr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vlrr_pkg::stat_t stat,
	output vlrr_pkg::cmd_t  cmd,
	output logic            busy
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_PB_HDR = 3'd2;
	localparam logic [2:0] S_POP_R1 = 3'd3;
	localparam logic [2:0] S_POP_R2 = 3'd4;
	localparam logic [2:0] S_POP_W  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (stat.mode)
					vlrr_pkg::MODE_BEGIN: begin
						if (stat.push_open) begin
							cmd.emit_code = 1'b1;
							cmd.code      = vlrr_pkg::ST_SEQ;
						end else if (!stat.fit) begin
							cmd.emit_code = 1'b1;
							cmd.code      = vlrr_pkg::ST_FULL;
						end else if (stat.wrap) begin
							cmd.wr_marker = 1'b1;
							state_d       = S_PB_HDR;
						end else begin
							cmd.wr_header = 1'b1;
						end
					end
					vlrr_pkg::MODE_WORD: begin
						if (stat.push_open) begin
							cmd.wr_word = 1'b1;
						end else begin
							cmd.emit_code = 1'b1;
							cmd.code      = vlrr_pkg::ST_SEQ;
						end
					end
					vlrr_pkg::MODE_POP: begin
						if (stat.empty) begin
							cmd.emit_code = 1'b1;
							cmd.code      = vlrr_pkg::ST_EMPTY;
						end else begin
							cmd.rd_rp = 1'b1;
							state_d   = S_POP_R1;
						end
					end
					default: begin
						cmd.emit_code = 1'b1;
						cmd.code      = vlrr_pkg::ST_SEQ;
					end
				endcase
			end
			S_PB_HDR: begin
				cmd.wr_header = 1'b1;
				state_d       = S_IDLE;
			end
			S_POP_R1: begin
				if (stat.marker) begin
					cmd.rd_zero = 1'b1;
					state_d     = S_POP_R2;
				end else begin
					cmd.pop_head = 1'b1;
					state_d      = stat.plen_zero ? S_IDLE : S_POP_W;
				end
			end
			S_POP_R2: begin
				cmd.pop_head = 1'b1;
				state_d      = stat.plen_zero ? S_IDLE : S_POP_W;
			end
			S_POP_W: begin
				cmd.pop_word = 1'b1;
				if (stat.cnt_last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = state_q != S_IDLE;

endmodule

/* rtl/variable_length_record_ring.sv */
// variable_length_record_ring: top level of the record ring; joins the
// controller and the datapath. Depends on vlrr_pkg, vlrr_ctrl, vlrr_dp.
//
// channel   handshake              payload
// item      start & !busy          item   (vlrr_pkg::item_t)
// result    res_stb, one cycle     res    (vlrr_pkg::res_t)
//
// Push begin: latch, header write, after a marker write when the record
// wraps (marker and header share the single ring write port). Push word:
// latch, word write. Pop: latch, header read (a second at 0 past a skip
// marker), results; one ring read per cycle. Results are registered.
// Reset clears pointers, counters and the push state; ring contents are not
// cleared. The receiver cannot stall; start is ignored while busy.
module variable_length_record_ring (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  vlrr_pkg::item_t item,
	output vlrr_pkg::res_t  res,
	output logic            res_stb
);

	vlrr_pkg::cmd_t  cmd;
	vlrr_pkg::stat_t stat;

	vlrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	vlrr_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.stat    (stat),
		.res     (res),
		.res_stb (res_stb)
	);

endmodule

/* rtl/vlrr_chk.sv */
// vlrr_chk: port-level assertions of the record ring, bound to the top
// level. Depends on vlrr_pkg and variable_length_record_ring.
module vlrr_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input vlrr_pkg::res_t  res,
	input logic            res_stb
);

	// an accepted transaction keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after accepted transaction");

	// single-result outcomes are always the last result
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && (res.status == vlrr_pkg::ST_ACCEPT || res.status == vlrr_pkg::ST_FULL ||
		res.status == vlrr_pkg::ST_SEQ || res.status == vlrr_pkg::ST_EMPTY) |-> res.last)
		else $error("single-result transaction without last");

	a_empty_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.status == vlrr_pkg::ST_HEADER && res.data_res == 32'd0 |-> res.last)
		else $error("empty record header without last");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb |-> 32'(res.used_words) <= 32'(vlrr_pkg::RING_WORDS))
		else $error("used words beyond ring size");

	// a payload word result is always followed by another word or ends the record
	a_word_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res_stb && res.status == vlrr_pkg::ST_WORD && !res.last |=>
		res_stb && res.status == vlrr_pkg::ST_WORD)
		else $error("record word stream broken");

endmodule

bind variable_length_record_ring vlrr_chk u_vlrr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.res     (res),
	.res_stb (res_stb)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for variable_length_record_ring; mirrors the ring, its
// pointers and the open push, and checks each result transaction. Depends on vlrr_pkg.
module testbench;
	import vlrr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	item_t item;
	res_t  res;
	logic  res_stb;

	variable_length_record_ring dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.res    (res),
		.res_stb(res_stb)
	);

	logic [31:0]   ring_mem [RING_WORDS];
	logic [AW-1:0] wr_pos;
	logic [AW-1:0] rd_pos;
	logic [AW-1:0] fill_pos;
	logic [CW-1:0] used;
	logic [CW-1:0] reserve;
	logic [3:0]    words_left;
	logic          open_push;
	logic [2:0]    push_status;

	res_t res_due[$];
	int   errors;
	int   cycles;
	int   idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d results outstanding", $time, res_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_res
		res_t want;
		if (arst_n && res_stb === 1'b1) begin
			if (res_due.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none got %p", $time, res);
			end else begin
				want = res_due.pop_front();
				report_field("status", want.status, res.status);
				report_field("tag_res", want.tag_res, res.tag_res);
				report_field("data_res", want.data_res, res.data_res);
				report_field("last", want.last, res.last);
				report_field("used_words", want.used_words, res.used_words);
			end
		end
	end

	function automatic void commit_record();
		wr_pos = AW'((wr_pos + reserve) % RING_WORDS);
		used = (used + reserve > RING_WORDS) ? CW'(RING_WORDS) : CW'(used + reserve);
		reserve = '0;
		words_left = '0;
		open_push = 1'b0;
	endfunction

	// results of one accepted transaction, appended in order to res_due
	function automatic void ring_advance(item_t it);
		int          alloc;
		int          tail;
		int          room;
		int          first;
		int          skip;
		int          total;
		int          plen;
		int          pos;
		logic        wraps;
		logic [31:0] head;
		res_t        r;
		r = '0;
		r.last = 1'b1;
		case (it.mode)
			MODE_BEGIN: begin
				if (open_push) begin
					r.status = ST_SEQ;
				end else if (it.length > MAX_PAYLOAD_WORDS) begin
					r.status = ST_FULL;
				end else begin
					alloc = 1 + it.length;
					tail = RING_WORDS - wr_pos;
					room = RING_WORDS - used;
					wraps = tail < alloc;
					first = wraps ? 0 : wr_pos;
					if (wraps)
						alloc += tail;
					if (room < alloc) begin
						r.status = ST_FULL;
					end else begin
						if (wraps)
							ring_mem[wr_pos] = '0;
						ring_mem[first] = {it.tag, 16'(1 + it.length)};
						reserve = CW'(alloc);
						words_left = it.length;
						fill_pos = AW'((first + 1) % RING_WORDS);
						open_push = 1'b1;
						if (it.length == 0)
							commit_record();
						r.status = ST_ACCEPT;
					end
				end
				push_status = r.status;
			end
			MODE_WORD: begin
				if (!open_push) begin
					r.status = ST_SEQ;
				end else begin
					ring_mem[fill_pos] = it.data;
					fill_pos = AW'((fill_pos + 1) % RING_WORDS);
					if (words_left > 0)
						words_left--;
					if (words_left == 0)
						commit_record();
					r.status = ST_ACCEPT;
				end
			end
			MODE_POP: begin
				if (used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// zero in the size field marks a skipped tail
					if (ring_mem[rd_pos][15:0] != 16'd0) begin
						first = rd_pos;
						skip = 0;
					end else begin
						first = 0;
						skip = RING_WORDS - rd_pos;
					end
					head = ring_mem[first];
					total = (head[15:0] == 16'd0) ? 1 : int'(head[15:0]);
					plen = (total - 1 > POP_MAX) ? POP_MAX : total - 1;
					rd_pos = AW'((rd_pos + skip + total) % RING_WORDS);
					used = (used > skip + total) ? CW'(used - (skip + total)) : '0;
					r.status = ST_HEADER;
					r.tag_res = head[31:16];
					r.data_res = plen;
					r.last = (plen == 0);
					r.used_words = used;
					res_due.push_back(r);
					pos = first;
					for (int i = 0; i < plen; i++) begin
						pos = (pos + 1) % RING_WORDS;
						r = '0;
						r.status = ST_WORD;
						r.data_res = ring_mem[pos];
						r.last = (i == plen - 1);
						r.used_words = used;
						res_due.push_back(r);
					end
					return;
				end
			end
			default: r.status = ST_SEQ;
		endcase
		r.used_words = used;
		res_due.push_back(r);
	endfunction

	task automatic send_item(input item_t it);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		ring_advance(it);
	endtask

	task automatic send_fields(input logic [1:0] mode, input logic [15:0] tag,
			input logic [3:0] length, input logic [31:0] data);
		item_t it;
		it.mode = mode;
		it.tag = tag;
		it.length = length;
		it.data = data;
		send_item(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (res_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_fields(MODE_POP, 16'h0000, 4'd0, 32'h0);
		send_fields(MODE_WORD, 16'h0000, 4'd0, 32'hFFFF_FFFF);
		send_fields(MODE_SPARE, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
		send_fields(MODE_BEGIN, 16'h0000, 4'd0, 32'h0);
		send_fields(MODE_BEGIN, 16'hFFFF, 4'd15, 32'h0);
		send_fields(MODE_BEGIN, 16'h1234, 4'd3, 32'h0);
		// pops while the push is open see only committed records
		send_fields(MODE_POP, 16'h0, 4'd0, 32'h0);
		send_fields(MODE_POP, 16'h0, 4'd0, 32'h0);
		send_fields(MODE_WORD, 16'h0, 4'd0, 32'hFFFF_FFFF);
		send_fields(MODE_WORD, 16'h0, 4'd0, 32'h0000_0000);
		for (int i = 0; i < 13; i++)
			send_fields(MODE_WORD, 16'h0, 4'd0, (i % 2) ? 32'h5A5A_5A5A : $urandom);
		send_fields(MODE_WORD, 16'h0, 4'd0, 32'h0);
		send_fields(MODE_POP, 16'h0, 4'd0, 32'h0);
		send_fields(MODE_POP, 16'h0, 4'd0, 32'h0);
	endtask

	task automatic test_fill();
		logic [3:0] len;
		do begin
			len = ($urandom_range(99) < 70) ? 4'd15 : 4'($urandom_range(15));
			send_fields(MODE_BEGIN, 16'($urandom), len, 32'h0);
			while (open_push)
				send_fields(MODE_WORD, 16'($urandom), 4'($urandom), $urandom);
		end while (push_status != ST_FULL);
		do
			send_fields(MODE_BEGIN, 16'($urandom), 4'd0, 32'h0);
		while (push_status != ST_FULL);
		send_fields(MODE_BEGIN, 16'($urandom), 4'd15, 32'h0);
		while (used != 0)
			send_fields(MODE_POP, 16'($urandom), 4'($urandom), $urandom);
		send_fields(MODE_POP, 16'h0, 4'd0, 32'h0);
	endtask

	task automatic test_random(input int count);
		item_t it;
		int    n;
		int    pick;
		n = 0;
		while (n < count) begin
			it.tag = 16'($urandom);
			it.length = 4'($urandom);
			it.data = $urandom;
			pick = $urandom_range(99);
			if (open_push)
				it.mode = (pick < 88) ? MODE_WORD : (pick < 93) ? MODE_POP :
					(pick < 97) ? MODE_BEGIN : MODE_SPARE;
			else
				it.mode = (pick < 50) ? MODE_BEGIN : (pick < 92) ? MODE_POP :
					(pick < 96) ? MODE_WORD : MODE_SPARE;
			if (!(it.mode == MODE_SPARE || (it.mode == MODE_WORD && !open_push) ||
					(it.mode == MODE_BEGIN && open_push)))
				n++;
			send_item(it);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 24;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		wr_pos = '0;
		rd_pos = '0;
		fill_pos = '0;
		used = '0;
		reserve = '0;
		words_left = '0;
		open_push = 1'b0;
		push_status = ST_ACCEPT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill();
		drain_results();
		test_random(127);
		drain_results();
		idle_pct = 67;
		test_random(127);
		drain_results();
		idle_pct = 0;
		test_random(126);
		drain_results();
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
